FILE: rtl/ffbta_pkg.sv
// ----------------------------------------------------------------------------
// First-fit block table allocator: shared definitions
// Types, codes and fixed widths used by the controller, datapath and checker.
// ----------------------------------------------------------------------------
package ffbta_pkg;

   // Fixed widths of the external payload fields.
   localparam int FIELD_W = 24;

   // Pool size after reset, before it is cut to the address width.
   localparam logic [31:0] POOL_RESET = 32'd65536;

   // Operation codes on req_func.
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Status codes on rsp_status.
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND_FIT,
      ST_WRITE_HIT,
      ST_FIND_HOLE,
      ST_WRITE_REM,
      ST_FIND_ADDR,
      ST_WRITE_FREE,
      ST_RESPOND
   } ffbta_state_type;

   // What the table scan compares each entry against.
   typedef enum logic [1:0] {
      SCAN_FIT,
      SCAN_HOLE,
      SCAN_ADDR
   } ffbta_scan_type;

   // Which table word the datapath writes this cycle.
   typedef enum logic [1:0] {
      WR_NONE,
      WR_HIT,
      WR_REM,
      WR_FREE
   } ffbta_write_type;

   typedef struct packed {
      logic            req_load;
      logic            scan_run;
      ffbta_scan_type  scan_kind;
      ffbta_write_type wr_kind;
      logic            rsp_load;
      logic            rsp_fail;
      logic            rsp_alloc;
   } ffbta_cmd_type;

   typedef struct packed {
      logic match;
      logic miss;
   } ffbta_sts_type;

endpackage

FILE: rtl/ffbta_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffbta_ram #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ffbta_ctrl.sv
// ----------------------------------------------------------------------------
// First-fit block table allocator: controller
// Sequences the table scans and writes of one item and hands out the result.
// ----------------------------------------------------------------------------
module ffbta_ctrl import ffbta_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_func,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  ffbta_sts_type sts,
   output ffbta_cmd_type cmd
);

   ffbta_state_type state_ff, state_in;
   logic            fail_ff, fail_in;
   logic            alloc_ff, alloc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == FUNC_FREE) ? ST_FIND_ADDR : ST_FIND_FIT;
            end
         end
         ST_FIND_FIT: begin
            if (sts.match) begin
               state_in = ST_WRITE_HIT;
            end else if (sts.miss) begin
               state_in = ST_RESPOND;
            end
         end
         ST_WRITE_HIT: state_in = ST_FIND_HOLE;
         ST_FIND_HOLE: begin
            if (sts.match) begin
               state_in = ST_WRITE_REM;
            end else if (sts.miss) begin
               state_in = ST_RESPOND;
            end
         end
         ST_WRITE_REM: state_in = ST_RESPOND;
         ST_FIND_ADDR: begin
            if (sts.match) begin
               state_in = ST_WRITE_FREE;
            end else if (sts.miss) begin
               state_in = ST_RESPOND;
            end
         end
         ST_WRITE_FREE: state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd           = '0;
      cmd.scan_kind = SCAN_FIT;
      cmd.wr_kind   = WR_NONE;
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.req_load = req_valid;
         end
         ST_FIND_FIT: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_kind = SCAN_FIT;
         end
         ST_WRITE_HIT: cmd.wr_kind = WR_HIT;
         ST_FIND_HOLE: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_kind = SCAN_HOLE;
         end
         ST_WRITE_REM: cmd.wr_kind = WR_REM;
         ST_FIND_ADDR: begin
            cmd.scan_run  = 1'b1;
            cmd.scan_kind = SCAN_ADDR;
         end
         ST_WRITE_FREE: cmd.wr_kind = WR_FREE;
         ST_RESPOND: begin
            cmd.rsp_load  = out_free;
            cmd.rsp_fail  = fail_ff;
            cmd.rsp_alloc = alloc_ff;
         end
         default: begin
            cmd.scan_run = 1'b0;
         end
      endcase
   end

   // Item flags and the output valid.
   always_comb begin
      fail_in      = fail_ff;
      alloc_in     = alloc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_IDLE && req_valid) begin
         fail_in  = 1'b0;
         alloc_in = (req_func == FUNC_ALLOC);
      end
      if ((state_ff == ST_FIND_FIT || state_ff == ST_FIND_ADDR) && sts.miss) begin
         fail_in = 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fail_ff      <= 1'b0;
         alloc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fail_ff      <= fail_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/ffbta_dpath.sv
// ----------------------------------------------------------------------------
// First-fit block table allocator: datapath
// Holds the block table, scans it one entry per cycle and writes it back.
// ----------------------------------------------------------------------------
module ffbta_dpath import ffbta_pkg::*; #(
   parameter int ENTRIES   = 32,
   parameter int ADDR_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [FIELD_W-1:0] csr_wr_data,
   input  logic [FIELD_W-1:0] req_amount,
   input  logic [FIELD_W-1:0] req_free_start,
   input  ffbta_cmd_type      cmd,
   output ffbta_sts_type      sts,
   output logic               rsp_status,
   output logic [FIELD_W-1:0] rsp_block_start
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int WORD_W = 2 * ADDR_BITS + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [ADDR_BITS-1:0] pool_ff, pool_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [ADDR_BITS-1:0] amount_ff, free_start_ff;
   logic [IDX_W-1:0]     hit_idx_ff, rem_idx_ff;
   logic [ADDR_BITS-1:0] hit_start_ff, hit_len_ff;
   logic                 rsp_status_ff;
   logic [FIELD_W-1:0]   rsp_start_ff;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [WORD_W-1:0]    wr_data;
   logic [WORD_W-1:0]    rd_data;
   logic [ADDR_BITS-1:0] ent_start, ent_len;
   logic                 ent_taken;
   logic                 cond;
   logic [ADDR_BITS-1:0] rem_start, rem_len;
   logic [CNT_W-1:0]     wr_top;

   ffbta_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Entries at or above the fill mark were never written since the table was
   // set up: they read as empty, except entry zero, which covers the pool.
   always_comb begin
      if (CNT_W'(chk_idx_ff) >= fill_ff) begin
         ent_start = '0;
         ent_len   = (chk_idx_ff == '0) ? pool_ff : '0;
         ent_taken = 1'b0;
      end else begin
         ent_start = rd_data[WORD_W-1 -: ADDR_BITS];
         ent_len   = rd_data[ADDR_BITS -: ADDR_BITS];
         ent_taken = rd_data[0];
      end
   end

   always_comb begin
      case (cmd.scan_kind)
         SCAN_FIT:  cond = !ent_taken && (ent_len >= amount_ff);
         SCAN_HOLE: cond = (ent_len == '0);
         SCAN_ADDR: cond = (ent_start == free_start_ff);
         default:   cond = 1'b0;
      endcase
      sts.match = cmd.scan_run && pend_ff && cond;
      sts.miss  = cmd.scan_run && pend_ff && !cond && (chk_idx_ff == LAST_IDX);
   end

   // One read is issued per cycle; its data is checked in the cycle after it is issued.
   always_comb begin
      if (cmd.scan_run) begin
         pend_in    = (rd_cnt_ff < CNT_W'(ENTRIES));
         chk_idx_in = rd_cnt_ff[IDX_W-1:0];
         rd_cnt_in  = pend_in ? rd_cnt_ff + CNT_W'(1) : rd_cnt_ff;
      end else begin
         pend_in    = 1'b0;
         chk_idx_in = chk_idx_ff;
         rd_cnt_in  = '0;
      end
   end

   assign rem_start = hit_start_ff + amount_ff;
   assign rem_len   = hit_len_ff - amount_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = hit_idx_ff;
      wr_data = {hit_start_ff, hit_len_ff, 1'b0};
      case (cmd.wr_kind)
         WR_HIT: begin
            wr_en   = 1'b1;
            wr_data = {hit_start_ff, amount_ff, 1'b1};
         end
         WR_REM: begin
            wr_en   = 1'b1;
            wr_addr = rem_idx_ff;
            wr_data = {rem_start, rem_len, 1'b0};
         end
         WR_FREE: wr_en = 1'b1;
         default: wr_en = 1'b0;
      endcase
   end

   assign wr_top = CNT_W'(wr_addr) + CNT_W'(1);

   always_comb begin
      pool_in = pool_ff;
      fill_in = fill_ff;
      if (csr_wr_en) begin
         pool_in = ADDR_BITS'(csr_wr_data);
         fill_in = '0;
      end else if (wr_en && wr_top > fill_ff) begin
         fill_in = wr_top;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff   <= ADDR_BITS'(POOL_RESET);
         fill_ff   <= '0;
         rd_cnt_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         pool_ff   <= pool_in;
         fill_ff   <= fill_in;
         rd_cnt_ff <= rd_cnt_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      if (cmd.req_load) begin
         amount_ff     <= ADDR_BITS'(req_amount);
         free_start_ff <= ADDR_BITS'(req_free_start);
      end
      if (sts.match) begin
         if (cmd.scan_kind == SCAN_HOLE) begin
            rem_idx_ff <= chk_idx_ff;
         end else begin
            hit_idx_ff   <= chk_idx_ff;
            hit_start_ff <= ent_start;
            hit_len_ff   <= ent_len;
         end
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_fail ? STATUS_FAIL : STATUS_OK;
         rsp_start_ff  <= (cmd.rsp_fail || !cmd.rsp_alloc) ? '0 : FIELD_W'(hit_start_ff);
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_block_start = rsp_start_ff;

endmodule

FILE: rtl/first_fit_block_table_allocator.sv
// ----------------------------------------------------------------------------
// First-fit block table allocator
// Allocates and frees blocks of a pool from a table of start/length entries.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   req_func, req_amount, req_free_start
//   rsp      out        rsp_valid/rsp_stall   rsp_status, rsp_block_start
//   csr      in         csr_wr_en             csr_wr_data (pool size)
//
// The time an allocate or a free takes is set by the table memory's single
// read port, which the scans walk one entry per cycle and stop at the first hit.
// One item is worked on at a time; req_stall is low only while idle.
// Reset and a pool size write set up the table at once, without a clearing
// pass. A stalled result waits in the output register.
// ----------------------------------------------------------------------------
module first_fit_block_table_allocator import ffbta_pkg::*; #(
   parameter int ENTRIES   = 32,
   parameter int ADDR_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [FIELD_W-1:0] csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [FIELD_W-1:0] req_amount,
   input  logic [FIELD_W-1:0] req_free_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_status,
   output logic [FIELD_W-1:0] rsp_block_start
);

   ffbta_cmd_type cmd;
   ffbta_sts_type sts;

   ffbta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffbta_dpath #(
      .ENTRIES   (ENTRIES),
      .ADDR_BITS (ADDR_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_amount      (req_amount),
      .req_free_start  (req_free_start),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_status      (rsp_status),
      .rsp_block_start (rsp_block_start)
   );

endmodule

FILE: rtl/ffbta_checker.sv
// ----------------------------------------------------------------------------
// First-fit block table allocator: port checker
// Watches the top level's ports and flags behavior the design must not show.
// ----------------------------------------------------------------------------
module ffbta_checker import ffbta_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_status,
   input logic [FIELD_W-1:0] rsp_block_start
);

   // A result held back by the receiver keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
                                 && $stable(rsp_block_start))
      else $error("stalled result changed");

   // A failed item always reports a zero start.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FAIL |-> rsp_block_start == '0)
      else $error("failure with nonzero block start");

   // Only one item is in work: after an accepted item the input is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // A new result appears only while an item was in work.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without an item in work");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind first_fit_block_table_allocator ffbta_checker u_ffbta_checker (.*);
